>>> sv/slam_pkg.sv
`default_nettype none
package slam_pkg;
    localparam int NumChannelsDef = 64;
    localparam int NumDevicesDef  = 16;
    localparam int ValueWidthDef  = 32;

    localparam logic [3:0] ReqSample     = 4'd0;
    localparam logic [3:0] ReqSetRule    = 4'd1;
    localparam logic [3:0] ReqRemoveRule = 4'd2;
    localparam logic [3:0] ReqClearRules = 4'd3;
    localparam logic [3:0] ReqAck        = 4'd4;
    localparam logic [3:0] ReqAckAll     = 4'd5;
    localparam logic [3:0] ReqClearAlarm = 4'd6;
    localparam logic [3:0] ReqClearAcked = 4'd7;
    localparam logic [3:0] ReqOffline    = 4'd8;
    localparam logic [3:0] ReqOnline     = 4'd9;

    localparam logic [2:0] EvNone    = 3'd0;
    localparam logic [2:0] EvRaised  = 3'd1;
    localparam logic [2:0] EvCleared = 3'd2;
    localparam logic [2:0] EvAcked   = 3'd3;
    localparam logic [2:0] EvBulk    = 3'd4;

    localparam logic [1:0] KindWindow  = 2'd0;
    localparam logic [1:0] KindRate    = 2'd1;
    localparam logic [1:0] KindOffline = 2'd2;

    localparam logic [1:0] LvlInfo     = 2'd0;
    localparam logic [1:0] LvlWarning  = 2'd1;
    localparam logic [1:0] LvlCritical = 2'd2;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [9:0]  channel;
        logic [7:0]  device;
        logic        to_offline;
        logic        ignore;
        logic [31:0] sample_value;
        logic [31:0] time_ms;
        logic        rule_kind;
        logic        rule_enabled;
        logic [31:0] low_limit;
        logic [31:0] high_limit;
        logic [30:0] rate_limit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [5:0] result_index;
        logic [1:0] level;
        logic [1:0] alarm_kind;
        logic       above_high;
        logic       active_now;
        logic       acked_now;
        logic [6:0] affected_count;
    } res_t;
endpackage
`default_nettype wire

>>> sv/slam_front.sv
`default_nettype none
module slam_front #(
    parameter int NUM_CHANNELS = 64,
    parameter int NUM_DEVICES  = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [3:0]      req_type,
    input  wire logic [5:0]      channel,
    input  wire logic [3:0]      device,
    input  wire logic            to_offline,
    input  wire logic [31:0]     sample_value,
    input  wire logic [31:0]     time_ms,
    input  wire logic            rule_kind,
    input  wire logic            rule_enabled,
    input  wire logic [31:0]     low_limit,
    input  wire logic [31:0]     high_limit,
    input  wire logic [30:0]     rate_limit,
    output slam_pkg::cmd_t       q_data,
    output logic                 q_valid,
    input  wire logic            q_pop,
    input  wire logic            back_busy
);
    import slam_pkg::*;

    logic   full_reg, full_next;
    cmd_t   cmd_reg, cmd_next;
    logic   per_ch, per_dev, bad;

    always_comb
    begin
        per_dev = (req_type >= ReqOffline)
            || ((req_type == ReqAck || req_type == ReqClearAlarm) && to_offline);
        per_ch  = (req_type <= ReqRemoveRule)
            || ((req_type == ReqAck || req_type == ReqClearAlarm) && !to_offline);
        bad = (req_type > ReqOnline)
            || (per_ch && (32'(channel) >= 32'(NUM_CHANNELS)))
            || (per_dev && (32'(device) >= 32'(NUM_DEVICES)));
    end

    assign busy    = full_reg || back_busy;
    assign q_valid = full_reg;
    assign q_data  = cmd_reg;

    always_comb
    begin
        full_next = full_reg;
        cmd_next  = cmd_reg;
        if (q_pop)
        begin
            full_next = 1'b0;
        end
        if (start && !busy)
        begin
            full_next             = 1'b1;
            cmd_next.req_type     = req_type;
            cmd_next.channel      = 10'(channel);
            cmd_next.device       = 8'(device);
            cmd_next.to_offline   = to_offline;
            cmd_next.ignore       = bad;
            cmd_next.sample_value = sample_value;
            cmd_next.time_ms      = time_ms;
            cmd_next.rule_kind    = rule_kind;
            cmd_next.rule_enabled = rule_enabled;
            cmd_next.low_limit    = low_limit;
            cmd_next.high_limit   = high_limit;
            cmd_next.rate_limit   = rate_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end
endmodule
`default_nettype wire

>>> sv/slam_back.sv
`default_nettype none
module slam_back #(
    parameter int NUM_CHANNELS = 64,
    parameter int NUM_DEVICES  = 16,
    parameter int VALUE_WIDTH  = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire slam_pkg::cmd_t  q_data,
    input  wire logic            q_valid,
    output logic                 q_pop,
    output logic                 back_busy,
    output logic                 res_valid,
    output slam_pkg::res_t       res
);
    import slam_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int VW = VALUE_WIDTH;
    localparam int NB = NUM_CHANNELS + NUM_DEVICES;
    localparam int BW = $clog2(NB + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_CALC, ST_MUL, ST_CMP, ST_WLVL, ST_DONE, ST_BULK
    } state_t;

    state_t state_reg;
    cmd_t   cmd_reg;

    logic [NUM_CHANNELS-1:0] rule_valid_reg, last_valid_reg;
    logic [NUM_CHANNELS-1:0] alarm_active_reg, alarm_acked_reg;
    logic [NUM_DEVICES-1:0]  off_active_reg, off_acked_reg;

    logic          rm_on [NUM_CHANNELS];
    logic          rm_type [NUM_CHANNELS];
    logic [VW-1:0] rm_lo [NUM_CHANNELS];
    logic [VW-1:0] rm_hi [NUM_CHANNELS];
    logic [30:0]   rm_rate [NUM_CHANNELS];
    logic [VW-1:0] lm_val [NUM_CHANNELS];
    logic [31:0]   lm_time [NUM_CHANNELS];

    logic          r_on_reg, r_type_reg;
    logic [VW-1:0] r_lo_reg, r_hi_reg, l_val_reg;
    logic [30:0]   r_rate_reg;
    logic [31:0]   l_time_reg;

    logic [VW:0]   dv_reg, span_reg, over_reg;
    logic [31:0]   dt_reg;
    logic          below_reg, above_reg;
    logic [42:0]   lhs_reg;
    logic [63:0]   rhs_reg;
    logic [VW+6:0] o10_reg, o50_reg;
    logic          outr_reg, crit_reg;

    logic [BW-1:0] idx_reg;
    logic [6:0]    cnt_reg;

    logic [CW-1:0] ch;
    logic [DW-1:0] dv_i;
    assign ch   = cmd_reg.channel[CW-1:0];
    assign dv_i = cmd_reg.device[DW-1:0];

    logic signed [VW:0] v_s, lo_s, hi_s, last_s, diff_s;
    always_comb
    begin
        v_s    = {cmd_reg.sample_value[VW-1], cmd_reg.sample_value[VW-1:0]};
        lo_s   = {r_lo_reg[VW-1], r_lo_reg};
        hi_s   = {r_hi_reg[VW-1], r_hi_reg};
        last_s = {l_val_reg[VW-1], l_val_reg};
        diff_s = v_s - last_s;
    end

    logic [31:0] dt_raw;
    assign dt_raw = cmd_reg.time_ms - l_time_reg;

    assign back_busy = (state_reg != ST_IDLE);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    function automatic res_t mk(input logic [2:0] ev, input logic [5:0] ix,
                                input logic [1:0] lv, input logic [1:0] kd,
                                input logic hb, input logic ac, input logic ak,
                                input logic [6:0] cn);
        res_t r;
        r.event_res = ev; r.result_index = ix; r.level = lv; r.alarm_kind = kd;
        r.above_high = hb; r.active_now = ac; r.acked_now = ak;
        r.affected_count = cn;
        return r;
    endfunction

    logic [5:0] ch6, dv6;
    assign ch6 = cmd_reg.channel[5:0];
    assign dv6 = cmd_reg.device[5:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_data.req_type == ReqSetRule
            && !q_data.ignore)
        begin
            rm_on[q_data.channel[CW-1:0]]   <= q_data.rule_enabled;
            rm_type[q_data.channel[CW-1:0]] <= q_data.rule_kind;
            rm_lo[q_data.channel[CW-1:0]]   <= q_data.low_limit[VW-1:0];
            rm_hi[q_data.channel[CW-1:0]]   <= q_data.high_limit[VW-1:0];
            rm_rate[q_data.channel[CW-1:0]] <= q_data.rate_limit;
        end
        if (state_reg == ST_READ)
        begin
            r_on_reg   <= rm_on[ch];
            r_type_reg <= rm_type[ch];
            r_lo_reg   <= rm_lo[ch];
            r_hi_reg   <= rm_hi[ch];
            r_rate_reg <= rm_rate[ch];
            l_val_reg  <= lm_val[ch];
            l_time_reg <= lm_time[ch];
        end
        if (state_reg == ST_CALC)
        begin
            lm_val[ch]  <= cmd_reg.sample_value[VW-1:0];
            lm_time[ch] <= cmd_reg.time_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            cmd_reg <= q_data;
        end
        if (state_reg == ST_CALC)
        begin
            dv_reg    <= diff_s[VW] ? (VW+1)'(-diff_s) : (VW+1)'(diff_s);
            dt_reg    <= (!last_valid_reg[ch]) ? 32'd1 :
                         ((dt_raw == 32'd0) ? 32'd1 : dt_raw);
            span_reg  <= (hi_s - lo_s < 1) ? (VW+1)'(1) : (VW+1)'(hi_s - lo_s);
            above_reg <= v_s > hi_s;
            below_reg <= v_s < lo_s;
            over_reg  <= (v_s > hi_s) ? (VW+1)'(v_s - hi_s) :
                         ((v_s < lo_s) ? (VW+1)'(lo_s - v_s) : '0);
        end
        if (state_reg == ST_MUL)
        begin
            lhs_reg <= 43'(dv_reg) * 43'd1000;
            rhs_reg <= 64'(r_rate_reg) * 64'(dt_reg);
            o10_reg <= (VW+7)'(over_reg) * (VW+7)'(10);
            o50_reg <= (VW+7)'(over_reg) * (VW+7)'(50);
        end
        if (state_reg == ST_CMP)
        begin
            outr_reg <= r_type_reg ? (last_valid_reg[ch] && (65'(lhs_reg) > 65'(rhs_reg)))
                                   : (above_reg || below_reg);
            crit_reg <= 65'(lhs_reg) > {rhs_reg, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rule_valid_reg   <= '0;
            last_valid_reg   <= '0;
            alarm_active_reg <= '0;
            alarm_acked_reg  <= '0;
            off_active_reg   <= '0;
            off_acked_reg    <= '0;
            res_valid        <= 1'b0;
            res              <= '0;
            idx_reg          <= '0;
            cnt_reg          <= '0;
        end
        else
        begin
            res_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_DONE;
                        if (!q_data.ignore && q_data.req_type == ReqSample)
                        begin
                            state_reg <= ST_READ;
                        end
                        if (!q_data.ignore && (q_data.req_type == ReqAckAll
                            || q_data.req_type == ReqClearAcked))
                        begin
                            state_reg <= ST_BULK;
                            idx_reg   <= '0;
                            cnt_reg   <= '0;
                        end
                    end
                end
                ST_READ: state_reg <= ST_CALC;
                ST_CALC:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: state_reg <= ST_CMP;
                ST_CMP: state_reg <= ST_WLVL;
                ST_WLVL:
                begin
                    state_reg <= ST_IDLE;
                    res_valid <= 1'b1;
                    last_valid_reg[ch] <= 1'b1;
                    if (!rule_valid_reg[ch] || !r_on_reg
                        || (r_type_reg && r_rate_reg == '0))
                    begin
                        res <= mk(EvNone, ch6, LvlInfo, KindWindow, 1'b0,
                                  alarm_active_reg[ch], alarm_acked_reg[ch], '0);
                    end
                    else if (outr_reg && !alarm_active_reg[ch])
                    begin
                        alarm_active_reg[ch] <= 1'b1;
                        alarm_acked_reg[ch]  <= 1'b0;
                        res <= mk(EvRaised, ch6,
                            r_type_reg ? (crit_reg ? LvlCritical : LvlWarning)
                            : ((o10_reg >= (VW+7)'(span_reg)) ? LvlCritical
                            : ((o50_reg >= (VW+7)'(span_reg)) ? LvlWarning : LvlInfo)),
                            r_type_reg ? KindRate : KindWindow,
                            !r_type_reg && above_reg, 1'b1, 1'b0, '0);
                    end
                    else if (!outr_reg && alarm_active_reg[ch])
                    begin
                        alarm_active_reg[ch] <= 1'b0;
                        alarm_acked_reg[ch]  <= 1'b0;
                        res <= mk(EvCleared, ch6, LvlInfo,
                                  r_type_reg ? KindRate : KindWindow, 1'b0, 1'b0, 1'b0, '0);
                    end
                    else
                    begin
                        res <= mk(EvNone, ch6, LvlInfo, KindWindow, 1'b0,
                                  alarm_active_reg[ch], alarm_acked_reg[ch], '0);
                    end
                end
                ST_BULK:
                begin
                    if (32'(idx_reg) < 32'(NB))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (32'(idx_reg) < 32'(NUM_CHANNELS))
                        begin
                            if (cmd_reg.req_type == ReqAckAll)
                            begin
                                if (alarm_active_reg[idx_reg[CW-1:0]]
                                    && !alarm_acked_reg[idx_reg[CW-1:0]])
                                begin
                                    alarm_acked_reg[idx_reg[CW-1:0]] <= 1'b1;
                                    cnt_reg <= (cnt_reg == 7'd127) ? cnt_reg : cnt_reg + 1'b1;
                                end
                            end
                            else if (alarm_active_reg[idx_reg[CW-1:0]]
                                     && alarm_acked_reg[idx_reg[CW-1:0]])
                            begin
                                alarm_active_reg[idx_reg[CW-1:0]] <= 1'b0;
                                alarm_acked_reg[idx_reg[CW-1:0]]  <= 1'b0;
                                cnt_reg <= (cnt_reg == 7'd127) ? cnt_reg : cnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            if (cmd_reg.req_type == ReqAckAll)
                            begin
                                if (off_active_reg[DW'(idx_reg - BW'(NUM_CHANNELS))]
                                    && !off_acked_reg[DW'(idx_reg - BW'(NUM_CHANNELS))])
                                begin
                                    off_acked_reg[DW'(idx_reg - BW'(NUM_CHANNELS))] <= 1'b1;
                                    cnt_reg <= (cnt_reg == 7'd127) ? cnt_reg : cnt_reg + 1'b1;
                                end
                            end
                            else if (off_active_reg[DW'(idx_reg - BW'(NUM_CHANNELS))]
                                     && off_acked_reg[DW'(idx_reg - BW'(NUM_CHANNELS))])
                            begin
                                off_active_reg[DW'(idx_reg - BW'(NUM_CHANNELS))] <= 1'b0;
                                off_acked_reg[DW'(idx_reg - BW'(NUM_CHANNELS))]  <= 1'b0;
                                cnt_reg <= (cnt_reg == 7'd127) ? cnt_reg : cnt_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        res_valid <= 1'b1;
                        res <= mk(EvBulk, '0, LvlInfo, KindWindow, 1'b0, 1'b0, 1'b0, cnt_reg);
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                    res_valid <= 1'b1;
                    res <= '0;
                    if (!cmd_reg.ignore)
                    begin
                        unique case (cmd_reg.req_type)
                            ReqSetRule:
                            begin
                                rule_valid_reg[ch] <= 1'b1;
                                res <= mk(EvNone, ch6, LvlInfo, KindWindow, 1'b0,
                                          alarm_active_reg[ch], alarm_acked_reg[ch], '0);
                            end
                            ReqRemoveRule:
                            begin
                                rule_valid_reg[ch] <= 1'b0;
                                res <= mk(EvNone, ch6, LvlInfo, KindWindow, 1'b0,
                                          alarm_active_reg[ch], alarm_acked_reg[ch], '0);
                            end
                            ReqClearRules:
                            begin
                                rule_valid_reg <= '0;
                                res <= mk(EvBulk, '0, LvlInfo, KindWindow, 1'b0, 1'b0, 1'b0, '0);
                            end
                            ReqAck:
                            begin
                                if (cmd_reg.to_offline)
                                begin
                                    if (off_active_reg[dv_i])
                                    begin
                                        off_acked_reg[dv_i] <= 1'b1;
                                    end
                                    res <= mk((off_active_reg[dv_i] && !off_acked_reg[dv_i])
                                              ? EvAcked : EvNone, dv6, LvlInfo, KindOffline,
                                              1'b0, off_active_reg[dv_i],
                                              off_active_reg[dv_i] || off_acked_reg[dv_i], '0);
                                end
                                else
                                begin
                                    if (alarm_active_reg[ch])
                                    begin
                                        alarm_acked_reg[ch] <= 1'b1;
                                    end
                                    res <= mk((alarm_active_reg[ch] && !alarm_acked_reg[ch])
                                              ? EvAcked : EvNone, ch6, LvlInfo, KindWindow,
                                              1'b0, alarm_active_reg[ch],
                                              alarm_active_reg[ch] || alarm_acked_reg[ch], '0);
                                end
                            end
                            ReqClearAlarm:
                            begin
                                if (cmd_reg.to_offline)
                                begin
                                    if (off_active_reg[dv_i])
                                    begin
                                        off_active_reg[dv_i] <= 1'b0;
                                        off_acked_reg[dv_i]  <= 1'b0;
                                    end
                                    res <= mk(off_active_reg[dv_i] ? EvCleared : EvNone, dv6,
                                              LvlInfo, KindOffline, 1'b0, 1'b0,
                                              !off_active_reg[dv_i] && off_acked_reg[dv_i], '0);
                                end
                                else
                                begin
                                    if (alarm_active_reg[ch])
                                    begin
                                        alarm_active_reg[ch] <= 1'b0;
                                        alarm_acked_reg[ch]  <= 1'b0;
                                    end
                                    res <= mk(alarm_active_reg[ch] ? EvCleared : EvNone, ch6,
                                              LvlInfo, KindWindow, 1'b0, 1'b0,
                                              !alarm_active_reg[ch] && alarm_acked_reg[ch], '0);
                                end
                            end
                            ReqOffline:
                            begin
                                if (!off_active_reg[dv_i])
                                begin
                                    off_active_reg[dv_i] <= 1'b1;
                                    off_acked_reg[dv_i]  <= 1'b0;
                                    res <= mk(EvRaised, dv6, LvlCritical, KindOffline,
                                              1'b0, 1'b1, 1'b0, '0);
                                end
                                else
                                begin
                                    res <= mk(EvNone, dv6, LvlInfo, KindOffline, 1'b0, 1'b1,
                                              off_acked_reg[dv_i], '0);
                                end
                            end
                            ReqOnline:
                            begin
                                if (off_active_reg[dv_i])
                                begin
                                    off_active_reg[dv_i] <= 1'b0;
                                    off_acked_reg[dv_i]  <= 1'b0;
                                    res <= mk(EvCleared, dv6, LvlInfo, KindOffline,
                                              1'b0, 1'b0, 1'b0, '0);
                                end
                                else
                                begin
                                    res <= mk(EvNone, dv6, LvlInfo, KindOffline, 1'b0, 1'b0,
                                              off_acked_reg[dv_i], '0);
                                end
                            end
                            default: res <= '0;
                        endcase
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/sensor_limit_alarm_monitor.sv
// Rule and alarm requests pass the front register and the DONE state of the back;
// samples pass READ, CALC, MUL, CMP and WLVL; acknowledge all and clear
// acknowledged scan every channel and every device in the BULK state.
// One request at a time: a new one is taken only once the last has finished.
// done pulses one cycle per request; the receiver cannot stall.
// Reset clears all valid, alarm and acknowledge bits; rule and sample stores
// hold undefined data until written.
`default_nettype none
module sensor_limit_alarm_monitor #(
    parameter int NUM_CHANNELS = slam_pkg::NumChannelsDef,
    parameter int NUM_DEVICES  = slam_pkg::NumDevicesDef,
    parameter int VALUE_WIDTH  = slam_pkg::ValueWidthDef
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  req_type,
    input  wire logic [5:0]  channel,
    input  wire logic [3:0]  device,
    input  wire logic        to_offline,
    input  wire logic [31:0] sample_value,
    input  wire logic [31:0] time_ms,
    input  wire logic        rule_kind,
    input  wire logic        rule_enabled,
    input  wire logic [31:0] low_limit,
    input  wire logic [31:0] high_limit,
    input  wire logic [30:0] rate_limit,
    output logic             done,
    output logic [2:0]       event_res,
    output logic [5:0]       result_index,
    output logic [1:0]       level,
    output logic [1:0]       alarm_kind,
    output logic             above_high,
    output logic             active_now,
    output logic             acked_now,
    output logic [6:0]       affected_count
);
    import slam_pkg::*;

    cmd_t q_data;
    logic q_valid, q_pop, back_busy;
    res_t res;

    slam_front #(.NUM_CHANNELS(NUM_CHANNELS), .NUM_DEVICES(NUM_DEVICES)) u_front (
        .clk, .rst_n, .start, .busy, .req_type, .channel, .device, .to_offline,
        .sample_value, .time_ms, .rule_kind, .rule_enabled, .low_limit,
        .high_limit, .rate_limit, .q_data, .q_valid, .q_pop, .back_busy
    );

    slam_back #(.NUM_CHANNELS(NUM_CHANNELS), .NUM_DEVICES(NUM_DEVICES),
                .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk, .rst_n, .q_data, .q_valid, .q_pop, .back_busy,
        .res_valid(done), .res
    );

    assign event_res      = res.event_res;
    assign result_index   = res.result_index;
    assign level          = res.level;
    assign alarm_kind     = res.alarm_kind;
    assign above_high     = res.above_high;
    assign active_now     = res.active_now;
    assign acked_now      = res.acked_now;
    assign affected_count = res.affected_count;

    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");
    a_level_raise: assert property (@(posedge clk) disable iff (!rst_n)
        (done && event_res != EvRaised) |-> (level == LvlInfo))
        else $error("level set without raise");
endmodule
`default_nettype wire

>>> sim/tb.sv
`default_nettype none
module tb;
    import slam_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [3:0]  req_type;
        bit [5:0]  channel;
        bit [3:0]  device;
        bit        to_offline;
        bit [31:0] sample_value;
        bit [31:0] time_ms;
        bit        rule_kind;
        bit        rule_enabled;
        bit [31:0] low_limit;
        bit [31:0] high_limit;
        bit [30:0] rate_limit;
        bit        drain;
    } request_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    request_t cur;
    res_t got;

    request_t pending_reqs[$];
    res_t expected_events[$];
    int mismatches;
    int idle_left;
    int sent;
    bit xfer;
    bit [31:0] clock_ms;

    bit        rule_valid[64];
    bit        rule_on[64];
    bit        rule_type[64];
    longint    rule_lower[64];
    longint    rule_upper[64];
    bit [63:0] rule_rate[64];
    bit        last_valid[64];
    longint    last_value[64];
    bit [31:0] last_ms[64];
    bit        alarm_active[64];
    bit        alarm_acked[64];
    bit        dev_active[16];
    bit        dev_acked[16];

    sensor_limit_alarm_monitor u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(cur.req_type), .channel(cur.channel), .device(cur.device),
        .to_offline(cur.to_offline), .sample_value(cur.sample_value),
        .time_ms(cur.time_ms), .rule_kind(cur.rule_kind),
        .rule_enabled(cur.rule_enabled), .low_limit(cur.low_limit),
        .high_limit(cur.high_limit), .rate_limit(cur.rate_limit),
        .done(done), .event_res(got.event_res), .result_index(got.result_index),
        .level(got.level), .alarm_kind(got.alarm_kind), .above_high(got.above_high),
        .active_now(got.active_now), .acked_now(got.acked_now),
        .affected_count(got.affected_count)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic res_t make_res(bit [2:0] ev, bit [5:0] idx, bit [1:0] lvl,
                                      bit [1:0] kind, bit hi, bit act, bit ack,
                                      int cnt);
        res_t r;
        r.event_res = ev;
        r.result_index = idx;
        r.level = lvl;
        r.alarm_kind = kind;
        r.above_high = hi;
        r.active_now = act;
        r.acked_now = ack;
        r.affected_count = (cnt > 127) ? 7'd127 : cnt[6:0];
        return r;
    endfunction

    function automatic res_t sample_event(request_t it);
        bit [5:0] c;
        longint v;
        longint d;
        longint span;
        longint over;
        bit had;
        bit act;
        bit outr;
        bit hi;
        bit [1:0] lvl;
        bit [63:0] dv;
        bit [63:0] dt;
        c = it.channel;
        v = longint'($signed(it.sample_value));
        had = last_valid[c];
        act = alarm_active[c];
        dv = 0;
        dt = 1;
        if (had)
        begin
            d = v - last_value[c];
            dv = (d < 0) ? -d : d;
            dt = {32'd0, it.time_ms - last_ms[c]};
            if (dt == 0)
                dt = 1;
        end
        last_valid[c] = 1;
        last_value[c] = v;
        last_ms[c] = it.time_ms;
        if (!rule_valid[c] || !rule_on[c] || (rule_type[c] && rule_rate[c] == 0))
            return make_res(EvNone, c, 0, 0, 0, alarm_active[c], alarm_acked[c], 0);
        if (rule_type[c])
            outr = had && (dv * 64'd1000 > rule_rate[c] * dt);
        else
            outr = v < rule_lower[c] || v > rule_upper[c];
        if (outr && !act)
        begin
            hi = 0;
            if (rule_type[c])
                lvl = (dv * 64'd1000 > 64'd2 * rule_rate[c] * dt) ? LvlCritical : LvlWarning;
            else
            begin
                span = rule_upper[c] - rule_lower[c];
                if (span < 1)
                    span = 1;
                over = (v > rule_upper[c]) ? v - rule_upper[c] : rule_lower[c] - v;
                if (over * 10 >= span)
                    lvl = LvlCritical;
                else if (over * 50 >= span)
                    lvl = LvlWarning;
                else
                    lvl = LvlInfo;
                hi = v > rule_upper[c];
            end
            alarm_active[c] = 1;
            alarm_acked[c] = 0;
            return make_res(EvRaised, c, lvl, rule_type[c] ? KindRate : KindWindow,
                            hi, 1, 0, 0);
        end
        if (!outr && act)
        begin
            alarm_active[c] = 0;
            alarm_acked[c] = 0;
            return make_res(EvCleared, c, 0, rule_type[c] ? KindRate : KindWindow,
                            0, 0, 0, 0);
        end
        return make_res(EvNone, c, 0, 0, 0, alarm_active[c], alarm_acked[c], 0);
    endfunction

    function automatic res_t alarm_event(request_t it);
        bit [5:0] c;
        bit [3:0] d;
        int cnt;
        bit chg;
        c = it.channel;
        d = it.device;
        cnt = 0;
        case (it.req_type)
            ReqSample:
                return sample_event(it);
            ReqSetRule:
            begin
                rule_valid[c] = 1;
                rule_type[c] = it.rule_kind;
                rule_on[c] = it.rule_enabled;
                rule_lower[c] = longint'($signed(it.low_limit));
                rule_upper[c] = longint'($signed(it.high_limit));
                rule_rate[c] = {33'd0, it.rate_limit};
                return make_res(EvNone, c, 0, 0, 0, alarm_active[c], alarm_acked[c], 0);
            end
            ReqRemoveRule:
            begin
                rule_valid[c] = 0;
                return make_res(EvNone, c, 0, 0, 0, alarm_active[c], alarm_acked[c], 0);
            end
            ReqClearRules:
            begin
                foreach (rule_valid[i])
                    rule_valid[i] = 0;
                return make_res(EvBulk, 0, 0, 0, 0, 0, 0, 0);
            end
            ReqAck:
                if (it.to_offline)
                begin
                    chg = dev_active[d] && !dev_acked[d];
                    if (chg)
                        dev_acked[d] = 1;
                    return make_res(chg ? EvAcked : EvNone, 6'(d), 0, KindOffline, 0,
                                    dev_active[d], dev_acked[d], 0);
                end
                else
                begin
                    chg = alarm_active[c] && !alarm_acked[c];
                    if (chg)
                        alarm_acked[c] = 1;
                    return make_res(chg ? EvAcked : EvNone, c, 0, KindWindow, 0,
                                    alarm_active[c], alarm_acked[c], 0);
                end
            ReqClearAlarm:
                if (it.to_offline)
                begin
                    chg = dev_active[d];
                    dev_active[d] = 0;
                    dev_acked[d] = chg ? 0 : dev_acked[d];
                    return make_res(chg ? EvCleared : EvNone, 6'(d), 0, KindOffline, 0,
                                    dev_active[d], dev_acked[d], 0);
                end
                else
                begin
                    chg = alarm_active[c];
                    alarm_active[c] = 0;
                    alarm_acked[c] = chg ? 0 : alarm_acked[c];
                    return make_res(chg ? EvCleared : EvNone, c, 0, KindWindow, 0,
                                    alarm_active[c], alarm_acked[c], 0);
                end
            ReqAckAll, ReqClearAcked:
            begin
                for (int i = 0; i < 64; i++)
                    if (it.req_type == ReqAckAll && alarm_active[i] && !alarm_acked[i])
                    begin
                        alarm_acked[i] = 1;
                        cnt++;
                    end
                    else if (it.req_type == ReqClearAcked && alarm_active[i] && alarm_acked[i])
                    begin
                        alarm_active[i] = 0;
                        alarm_acked[i] = 0;
                        cnt++;
                    end
                for (int i = 0; i < 16; i++)
                    if (it.req_type == ReqAckAll && dev_active[i] && !dev_acked[i])
                    begin
                        dev_acked[i] = 1;
                        cnt++;
                    end
                    else if (it.req_type == ReqClearAcked && dev_active[i] && dev_acked[i])
                    begin
                        dev_active[i] = 0;
                        dev_acked[i] = 0;
                        cnt++;
                    end
                return make_res(EvBulk, 0, 0, 0, 0, 0, 0, cnt);
            end
            ReqOffline:
                if (!dev_active[d])
                begin
                    dev_active[d] = 1;
                    dev_acked[d] = 0;
                    return make_res(EvRaised, 6'(d), LvlCritical, KindOffline, 0, 1, 0, 0);
                end
                else
                    return make_res(EvNone, 6'(d), 0, KindOffline, 0, 1, dev_acked[d], 0);
            ReqOnline:
                if (dev_active[d])
                begin
                    dev_active[d] = 0;
                    dev_acked[d] = 0;
                    return make_res(EvCleared, 6'(d), 0, KindOffline, 0, 0, 0, 0);
                end
                else
                    return make_res(EvNone, 6'(d), 0, KindOffline, 0, 0, dev_acked[d], 0);
            default:
                return make_res(EvNone, 0, 0, 0, 0, 0, 0, 0);
        endcase
    endfunction

    // accept transfers, predict, check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result ev=%0d idx=%0d", got.event_res,
                                 got.result_index);
                end
                else if (got !== expected_events[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp ev=%0d idx=%0d lvl=%0d kind=%0d hi=%0d act=%0d ack=%0d cnt=%0d / got ev=%0d idx=%0d lvl=%0d kind=%0d hi=%0d act=%0d ack=%0d cnt=%0d",
                            expected_events[0].event_res, expected_events[0].result_index,
                            expected_events[0].level, expected_events[0].alarm_kind,
                            expected_events[0].above_high, expected_events[0].active_now,
                            expected_events[0].acked_now, expected_events[0].affected_count,
                            got.event_res, got.result_index, got.level, got.alarm_kind,
                            got.above_high, got.active_now, got.acked_now,
                            got.affected_count);
                    void'(expected_events.pop_front());
                end
                else
                    void'(expected_events.pop_front());
            end
            if (start && !busy)
                expected_events.push_back(alarm_event(cur));
        end
        xfer <= rst_n && start && !busy;
    end

    // present requests
    always @(negedge clk)
    begin
        logic s;
        s = start;
        if (s && xfer)
            s = 1'b0;
        if (rst_n && !s)
        begin
            if (idle_left > 0)
                idle_left--;
            else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_events.size() > 0))
            begin
                cur <= pending_reqs.pop_front();
                s = 1'b1;
                sent++;
                if (pending_reqs.size() > 150 && ((sent / 100) % 3 != 0) &&
                    $urandom_range(0, 3) == 0)
                    idle_left = $urandom_range(1, 8);
            end
        end
        start <= s;
    end

    function automatic request_t noise_req();
        request_t r;
        r.req_type = 4'($urandom);
        r.channel = 6'($urandom);
        r.device = 4'($urandom);
        r.to_offline = 1'($urandom);
        r.sample_value = $urandom;
        r.time_ms = $urandom;
        r.rule_kind = 1'($urandom);
        r.rule_enabled = 1'($urandom);
        r.low_limit = $urandom;
        r.high_limit = $urandom;
        r.rate_limit = 31'($urandom);
        r.drain = 0;
        return r;
    endfunction

    task automatic push_req(bit [3:0] rq, bit [5:0] ch, bit [3:0] dv, bit off,
                            bit [31:0] val, bit [31:0] ms);
        request_t r;
        r = noise_req();
        r.req_type = rq;
        r.channel = ch;
        r.device = dv;
        r.to_offline = off;
        r.sample_value = val;
        r.time_ms = ms;
        pending_reqs.push_back(r);
    endtask

    task automatic push_rule(bit [5:0] ch, bit kind, bit en, bit [31:0] lo,
                             bit [31:0] hi, bit [30:0] rate);
        request_t r;
        r = noise_req();
        r.req_type = ReqSetRule;
        r.channel = ch;
        r.rule_kind = kind;
        r.rule_enabled = en;
        r.low_limit = lo;
        r.high_limit = hi;
        r.rate_limit = rate;
        pending_reqs.push_back(r);
    endtask

    function automatic bit [31:0] pick_value();
        int m;
        m = $urandom_range(0, 9);
        if (m < 7)
            return $urandom_range(0, 2400) - 1200;
        if (m < 9)
            return $urandom;
        return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    initial
    begin
        int r;
        int m;
        bit [31:0] lo;
        bit [31:0] hi;
        bit [30:0] rate;
        rst_n = 1'b0;
        start = 1'b0;
        xfer = 1'b0;
        cur = noise_req();
        mismatches = 0;
        idle_left = 0;
        sent = 0;
        clock_ms = 0;

        push_req(ReqSample, 0, 0, 0, 32'd5, 32'd0);
        push_rule(0, 0, 1, -32'sd100, 32'd100, 0);
        push_req(ReqSample, 0, 0, 0, 32'd150, 32'd10);
        push_req(ReqSample, 0, 0, 0, 32'd100, 32'd20);
        push_req(ReqSample, 0, 0, 0, -32'sd101, 32'd30);
        push_req(ReqAck, 0, 0, 0, 0, 0);
        push_req(ReqAck, 0, 0, 0, 0, 0);
        push_req(ReqClearAlarm, 0, 0, 0, 0, 0);
        push_rule(1, 1, 1, 0, 0, 31'd10);
        push_req(ReqSample, 1, 0, 0, 32'd0, 32'hffff_fff0);
        push_req(ReqSample, 1, 0, 0, 32'd100, 32'd1000);
        push_req(ReqSample, 1, 0, 0, 32'd100, 32'd1000);
        push_rule(2, 1, 1, 0, 0, 31'd0);
        push_req(ReqSample, 2, 0, 0, 32'h7fff_ffff, 32'd0);
        push_rule(63, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        push_req(ReqSample, 63, 0, 0, 32'h8000_0000, 32'hffff_ffff);
        push_req(ReqOffline, 0, 15, 0, 0, 0);
        push_req(ReqOffline, 0, 15, 0, 0, 0);
        push_req(ReqAck, 0, 15, 1, 0, 0);
        push_req(ReqAckAll, 0, 0, 0, 0, 0);
        push_req(ReqClearAcked, 0, 0, 0, 0, 0);
        push_req(ReqOnline, 0, 15, 0, 0, 0);
        push_req(ReqRemoveRule, 1, 0, 0, 0, 0);
        push_req(ReqClearRules, 0, 0, 0, 0, 0);
        push_req(4'd15, 0, 0, 0, 0, 0);
        pending_reqs[$].drain = 1;

        for (int n = 0; n < 1400; n++)
        begin
            r = $urandom_range(0, 99);
            m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
            clock_ms += $urandom_range(0, 1500);
            if ($urandom_range(0, 19) == 0)
                clock_ms = $urandom;
            if (r < 55)
                push_req(ReqSample, 6'(m), 0, 0, pick_value(), clock_ms);
            else if (r < 65)
            begin
                case ($urandom_range(0, 9))
                    0: begin lo = $urandom; hi = $urandom; end
                    1: begin lo = pick_value(); hi = lo; end
                    2: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
                    default: begin lo = -$urandom_range(0, 1000); hi = $urandom_range(0, 1000); end
                endcase
                m = $urandom_range(0, 9);
                rate = 31'((m < 7) ? $urandom_range(0, 3000) : (m < 9) ? $urandom : 0);
                push_rule(6'($urandom_range(0, 7)), 1'($urandom), $urandom_range(0, 9) != 0,
                          lo, hi, rate);
            end
            else if (r < 68)
                push_req(ReqRemoveRule, 6'(m), 0, 0, 0, 0);
            else if (r < 69)
                push_req(ReqClearRules, 0, 0, 0, 0, 0);
            else if (r < 75)
                push_req(ReqAck, 6'(m), 4'($urandom), $urandom_range(0, 2) == 0, 0, 0);
            else if (r < 78)
                push_req(ReqAckAll, 0, 0, 0, 0, 0);
            else if (r < 84)
                push_req(ReqClearAlarm, 6'(m), 4'($urandom), $urandom_range(0, 2) == 0, 0, 0);
            else if (r < 87)
                push_req(ReqClearAcked, 0, 0, 0, 0, 0);
            else if (r < 92)
                push_req(ReqOffline, 0, 4'($urandom), 0, 0, 0);
            else if (r < 97)
                push_req(ReqOnline, 0, 4'($urandom), 0, 0, 0);
            else
                pending_reqs.push_back(noise_req());
            if (n == 700)
                pending_reqs[$].drain = 1;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() > 0 || start)
            @(posedge clk);
        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
